### sv/isqe_pkg.sv
`default_nettype none

package isqe_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 1024;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 11;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 11;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Beat layouts, lowest field first
    localparam int ACT_LSB     = 0;
    localparam int POS_LSB     = ACT_LSB + ACT_W;
    localparam int VAL_LSB     = POS_LSB + POS_W;
    localparam int IN_USED_W   = VAL_LSB + DATA_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    localparam int RD_LSB      = 0;
    localparam int ST_LSB      = RD_LSB + DATA_W;
    localparam int LEN_LSB     = ST_LSB + ST_W;
    localparam int OUT_USED_W  = LEN_LSB + LEN_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Read-back OR tree
    localparam int TREE_FAN = 32;

    function automatic int lvl_nodes(input int lvl);
        int n;
        n = CAPACITY;
        for (int i = 0; i <= lvl; i++)
        begin
            n = (n + TREE_FAN - 1) / TREE_FAN;
        end
        return n;
    endfunction

    function automatic int tree_depth();
        int n;
        int d;
        n = CAPACITY;
        d = 0;
        while (n > 1)
        begin
            n = (n + TREE_FAN - 1) / TREE_FAN;
            d++;
        end
        return d;
    endfunction

    function automatic int tree_off(input int lvl);
        int s;
        s = 0;
        for (int m = 0; m < lvl; m++)
        begin
            s += lvl_nodes(m);
        end
        return s;
    endfunction

    localparam int TREE_LEVELS = tree_depth();
    localparam int TREE_NODES  = tree_off(TREE_LEVELS);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR     = 3'd0,
        ACT_APPEND    = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_DELETE    = 3'd3,
        ACT_OVERWRITE = 3'd4,
        ACT_READ      = 3'd5
    } act_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } st_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_WRITE
    } op_t;

    // Broadcast to every cell
    typedef struct packed {
        op_t               op;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

### sv/isqe_cell.sv
`default_nettype none

module isqe_cell
    import isqe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire cmd_t              cmd,
    input  wire logic [DATA_W-1:0] left,
    input  wire logic [DATA_W-1:0] right,
    output logic      [DATA_W-1:0] entry,
    output logic      [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [CMP_W-1:0]  my_pos;
    logic              hit;

    assign my_pos = CMP_W'(idx);
    assign hit    = (my_pos == cmd.pos);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (hit)
                    entry_next = cmd.value;
                else if (my_pos > cmd.pos)
                    entry_next = left;
            end
            OP_DELETE:
            begin
                if (my_pos >= cmd.pos)
                    entry_next = right;
            end
            OP_WRITE:
            begin
                if (hit)
                    entry_next = cmd.value;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // Drive the held entry onto the read tree only when addressed
    assign rd    = hit ? entry_reg : '0;

endmodule

`default_nettype wire

### sv/isqe_read_tree.sv
`default_nettype none

module isqe_read_tree
    import isqe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [DATA_W-1:0] cell_rd [CAPACITY],
    output logic      [DATA_W-1:0] rd_data,
    output logic                   done
);

    logic [TREE_LEVELS-1:0] vld_reg;
    logic [TREE_NODES-1:0]  node_load;
    logic [DATA_W-1:0]      node_next [TREE_NODES];
    logic [DATA_W-1:0]      node_reg  [TREE_NODES];

    for (genvar l = 0; l < TREE_LEVELS; l++)
    begin : g_lvl
        localparam int NODES   = lvl_nodes(l);
        localparam int SRC_N   = (l == 0) ? CAPACITY : lvl_nodes(l - 1);
        localparam int OFF     = tree_off(l);
        localparam int SRC_OFF = (l == 0) ? 0 : tree_off(l - 1);

        for (genvar j = 0; j < NODES; j++)
        begin : g_node
            logic [DATA_W-1:0] leaf [TREE_FAN];
            logic [DATA_W-1:0] or_val;

            for (genvar k = 0; k < TREE_FAN; k++)
            begin : g_in
                if (j * TREE_FAN + k >= SRC_N)
                begin : g_pad
                    assign leaf[k] = '0;
                end
                else if (l == 0)
                begin : g_cell
                    assign leaf[k] = cell_rd[j * TREE_FAN + k];
                end
                else
                begin : g_node_in
                    assign leaf[k] = node_reg[SRC_OFF + j * TREE_FAN + k];
                end
            end

            always_comb
            begin
                or_val = '0;
                for (int k = 0; k < TREE_FAN; k++)
                begin
                    or_val = or_val | leaf[k];
                end
            end

            assign node_next[OFF + j] = or_val;
            if (l == 0)
            begin : g_ld0
                assign node_load[OFF + j] = load;
            end
            else
            begin : g_ldn
                assign node_load[OFF + j] = vld_reg[l - 1];
            end
        end
    end

    // Advance the level strobes one stage per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= TREE_LEVELS'({vld_reg, load});
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < TREE_NODES; n++)
        begin
            if (node_load[n])
                node_reg[n] <= node_next[n];
        end
    end

    assign rd_data = node_reg[TREE_NODES-1];
    assign done    = vld_reg[TREE_LEVELS-1];

endmodule

`default_nettype wire

### sv/indexed_sequence_editor.sv
// Indexed sequence editor: an ordered list of up to CAPACITY (1024) signed
// 32-bit values, edited by one command per input beat: clear, append, insert
// before a position, delete at a position, overwrite at a position, or read at
// a position. Every command returns exactly one output beat carrying the value
// read (zero unless a read hits), a status (done, position beyond end, store
// full) and the list length after the command. The list lives in a row of
// identical cells, one entry each; an insert shifts the cells above the
// position up by one and a delete shifts them down, all cells moving together
// in the cycle the command beat is taken. A read gathers the addressed cell
// through a registered OR tree of fan-in 32 (two levels at 1024 entries), and
// every command's result beat is registered after the tree's last level is
// loaded. One command is in flight at a time: s_tready is low from the command
// beat until its result beat is taken. An insert at or past the end appends;
// append or insert on a full list is rejected; delete, overwrite or read past
// the end leaves the list untouched and reports the position as beyond end.
// Action codes 6 and 7 change nothing and report done. Entries are undefined
// until written, and no reset clears them; only the length is reset.
`default_nettype none

module indexed_sequence_editor
    import isqe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Command channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // action[2:0], position[13:3], value[45:14], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // read_value[31:0], status[33:32], length[44:34], zero fill above
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    st_t               st_reg;
    st_t               st_next;
    logic              rd_en_reg;
    logic              rd_en_next;
    logic [DATA_W-1:0] rd_reg;
    logic [LEN_W-1:0]  len_reg;

    act_t              act;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  count_w;
    logic [DATA_W-1:0] value;
    logic              full;
    logic              in_accept;
    op_t               op;
    logic [CMP_W-1:0]  at;
    cmd_t              cmd;

    logic [DATA_W-1:0] entry_w [CAPACITY];
    logic [DATA_W-1:0] cell_rd [CAPACITY];
    logic [DATA_W-1:0] tree_data;
    logic              tree_done;

    // Unpack the command beat
    assign act     = act_t'(s_tdata[ACT_LSB +: ACT_W]);
    assign pos_w   = CMP_W'(s_tdata[POS_LSB +: POS_W]);
    assign value   = s_tdata[VAL_LSB +: DATA_W];
    assign count_w = CMP_W'(count_reg);
    assign full    = (count_w == CMP_W'(CAPACITY));

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Work out the edit and its status from the current length
    always_comb
    begin
        op         = OP_HOLD;
        at         = pos_w;
        st_next    = ST_DONE;
        count_next = count_reg;
        rd_en_next = 1'b0;
        case (act)
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            ACT_APPEND, ACT_INSERT:
            begin
                if (full)
                    st_next = ST_FULL;
                else
                begin
                    op = OP_INSERT;
                    // Clamp to the tail: append, or insert past the end
                    if ((act == ACT_APPEND) || (pos_w > count_w))
                        at = count_w;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (pos_w >= count_w)
                    st_next = ST_MISS;
                else
                begin
                    op         = OP_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_OVERWRITE:
            begin
                if (pos_w >= count_w)
                    st_next = ST_MISS;
                else
                    op = OP_WRITE;
            end
            ACT_READ:
            begin
                if (pos_w >= count_w)
                    st_next = ST_MISS;
                else
                    rd_en_next = 1'b1;
            end
            default:
            begin
                op = OP_HOLD;
            end
        endcase
    end

    // Broadcast the edit to the cells only on a taken beat
    assign cmd.op    = in_accept ? op : OP_HOLD;
    assign cmd.pos   = at;
    assign cmd.value = value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = entry_w[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = entry_w[i + 1];
        end

        isqe_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(i)),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .entry (entry_w[i]),
            .rd    (cell_rd[i])
        );
    end

    isqe_read_tree u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (in_accept),
        .cell_rd (cell_rd),
        .rd_data (tree_data),
        .done    (tree_done)
    );

    // Sequencer: take a beat, wait for the tree, hold the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            st_reg    <= ST_DONE;
            rd_en_reg <= 1'b0;
            rd_reg    <= '0;
            len_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        count_reg <= count_next;
                        st_reg    <= st_next;
                        rd_en_reg <= rd_en_next;
                        len_reg   <= LEN_W'(count_next);
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY:
                begin
                    if (tree_done)
                    begin
                        rd_reg    <= rd_en_reg ? tree_data : '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), len_reg, st_reg, rd_reg};

endmodule

`default_nettype wire

### sv/isqe_checker.sv
`default_nettype none

module isqe_assertions
    import isqe_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [ST_W-1:0]   chk_st;
    logic [LEN_W-1:0]  chk_len;
    logic [DATA_W-1:0] chk_rd;
    logic [ACT_W-1:0]  chk_act;

    assign chk_st  = m_tdata[ST_LSB +: ST_W];
    assign chk_len = m_tdata[LEN_LSB +: LEN_W];
    assign chk_rd  = m_tdata[RD_LSB +: DATA_W];
    assign chk_act = s_tdata[ACT_LSB +: ACT_W];

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No new command is accepted while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("command taken while result pending");

    // Length never passes the store size
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (LEN_W + 1)'(chk_len) <= (LEN_W + 1)'(CAPACITY))
        else $error("length beyond capacity");

    // A non-zero value only comes back with status done
    a_rd_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (chk_rd != '0) |-> chk_st == ST_DONE)
        else $error("read value with failing status");

    // A clear reports an empty list once the read tree has drained
    a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (chk_act == ACT_CLEAR) |=>
            !m_tvalid [*TREE_LEVELS] ##1 (m_tvalid && (chk_len == '0)))
        else $error("clear did not report an empty list");

endmodule

bind indexed_sequence_editor isqe_assertions u_isqe_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
